// ===== sv/cosg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the circle outline segment generator.
package cosg_pkg;

  localparam int CoordW      = 20;
  localparam int RadiusW     = 18;
  localparam int VertexCountW = 7;
  localparam int CanvasW     = 14;
  localparam int ThickW      = 8;
  localparam int PhaseW      = 16;
  localparam int CoefW       = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 14;

  // Full turn on the phase scale; divided by the vertex count to get the step.
  localparam logic [PhaseW:0] FullTurn = 17'h1_0000;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = 20'sh7FFFF;
  localparam coord_t CoordMin = 20'sh80000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_LINE_WIDTH    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0]  center_x;
    logic signed [CoordW-1:0]  center_y;
    logic [RadiusW-1:0]        radius;
    logic [VertexCountW-1:0]   vertex_count;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic                     visible;
    logic [ThickW-1:0]        thickness;
    logic                     last;
  } out_item_t;

  // Saturate a one-bit-wider sum back to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [CoordW:0] v);
    coord_t res;
    if (v[CoordW] != v[CoordW-1]) begin
      res = v[CoordW] ? CoordMin : CoordMax;
    end else begin
      res = v[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/cosg_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module cosg_div #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_d;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign rem_d   = ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIVIDEND_W);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/cosg_sine_rom.sv =====
`timescale 1ns / 1ps
// Q1.15 sine table over one turn, built at elaboration, registered read.
module cosg_sine_rom #(
  parameter int DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic [$clog2(DEPTH)-1:0]        addr_i,
  output logic signed [cosg_pkg::CoefW-1:0] data_o
);
  import cosg_pkg::*;

  // Quarter-wave symmetry plus an odd polynomial in Q16.
  function automatic logic signed [CoefW-1:0] sine_val(input int unsigned k);
    longint unsigned k4, q, m, xq, x, x2, t, s, mag;
    logic signed [CoefW-1:0] v;
    k4  = longint'(k % DEPTH) * 4;
    q   = k4 / DEPTH;
    m   = k4 - q * DEPTH;
    xq  = (m << 16) / DEPTH;
    x   = q[0] ? (65536 - xq) : xq;
    x2  = (x * x) >> 16;
    t   = (5223 * x2) >> 16;
    t   = 42334 - t;
    t   = (t * x2) >> 16;
    t   = 102944 - t;
    s   = (t * x) >> 16;
    mag = (s + 1) >> 1;
    if (mag > 32767) mag = 32767;
    v = CoefW'(mag);
    if (q >= 2) v = -v;
    return v;
  endfunction

  logic signed [CoefW-1:0] rom [DEPTH];
  logic signed [CoefW-1:0] data_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom[g] = sine_val(g);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== sv/cosg_scale.sv =====
`timescale 1ns / 1ps
// Radius times table coefficient, rounded half away from zero back to 1/16 pixel.
module cosg_scale (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [cosg_pkg::RadiusW-1:0]      radius_i,
  input  logic signed [cosg_pkg::CoefW-1:0] coef_i,
  output logic [cosg_pkg::RadiusW-1:0]      mag_o,
  output logic                              neg_o
);
  import cosg_pkg::*;

  localparam int ProdW = RadiusW + CoefW - 1;

  logic [CoefW-2:0]   coef_mag;
  logic [ProdW-1:0]   prod;
  logic [ProdW:0]     rounded;
  logic [RadiusW-1:0] mag_q;
  logic               neg_q;

  // Table magnitude never exceeds 32767, so the negation fits.
  assign coef_mag = coef_i[CoefW-1] ? (CoefW-1)'(-coef_i) : coef_i[CoefW-2:0];
  assign prod     = ProdW'(radius_i) * ProdW'(coef_mag);
  assign rounded  = (ProdW+1)'(prod) + (ProdW+1)'(16384);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rounded[15 +: RadiusW];
      neg_q <= coef_i[CoefW-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ===== sv/circle_outline_segment_generator.sv =====
`timescale 1ns / 1ps
// The step divider runs after a request transfer; then each vertex passes through the states
// S_INDEX, S_SIN_RD, S_SIN_MUL, S_X, S_COS_RD, S_COS_MUL, S_Y and S_VERT through the shared
// table lookup and multiplier, and S_CLOSE emits the closing segment. A request waits in
// S_VERT and S_CLOSE while the output register is full; one request at a time.
// Reset clears the sequencer and output valid and loads the canvas registers with
// 1920 x 1080 and line width 1; no memory clearing pass.
module circle_outline_segment_generator #(
  parameter int MAX_VERTICES     = 64,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COORD_FRAC_BITS  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cosg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cosg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cosg_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cosg_pkg::out_item_t               out_item_o
);
  import cosg_pkg::*;

  localparam int NW      = $clog2(MAX_VERTICES + 1);
  localparam int CW      = $clog2(MAX_VERTICES);
  localparam int KW      = $clog2(SINE_TABLE_DEPTH);
  localparam int DBW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int CLW     = (NW > VertexCountW) ? NW : VertexCountW;
  localparam int WW      = CanvasW + COORD_FRAC_BITS;
  localparam int CMPW    = (WW > CoordW - 1) ? WW : CoordW - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_INDEX, S_SIN_RD, S_SIN_MUL, S_X,
    S_COS_RD, S_COS_MUL, S_Y, S_VERT, S_CLOSE
  } state_e;

  // configuration
  logic [CanvasW-1:0] canvas_w_q, canvas_h_q;
  logic [ThickW-1:0]  line_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CanvasW'(1920);
      canvas_h_q <= CanvasW'(1080);
      line_w_q   <= ThickW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        REG_LINE_WIDTH:    line_w_q   <= cfg_data_i[ThickW-1:0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [CW-1:0]      cnt_q;
  logic [NW-1:0]      n_q;
  logic [PhaseW-1:0]  phase_q;
  logic [PhaseW-1:0]  step_q;
  coord_t             center_x_q, center_y_q;
  logic [RadiusW-1:0] radius_q;
  logic [KW-1:0]      k_q;
  coord_t             x_q, y_q;
  coord_t             first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic               first_on_q, prev_on_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  // request handshake and vertex count clamp
  logic           in_xfer;
  logic [CLW-1:0] vc_ext;
  logic [NW-1:0]  n_clamped;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign vc_ext     = CLW'(in_item_i.vertex_count);

  always_comb begin
    if (vc_ext == '0) begin
      n_clamped = NW'(1);
    end else if (vc_ext > CLW'(MAX_VERTICES)) begin
      n_clamped = NW'(MAX_VERTICES);
    end else begin
      n_clamped = NW'(vc_ext);
    end
  end

  // phase step = full turn / n
  logic              div_done;
  logic [PhaseW:0]   div_quot;

  cosg_div #(
    .DIVIDEND_W (PhaseW + 1),
    .DIVISOR_W  (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .dividend_i (FullTurn),
    .divisor_i  (n_clamped),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // table indexes for sine and cosine
  logic [PhaseW+DBW-1:0] k_prod;
  logic [KW-1:0]         k_next;
  logic [KW:0]           kc_sum;
  logic [KW:0]           kc_wrap;
  logic [KW-1:0]         kc;
  logic [KW-1:0]         rom_addr;
  logic signed [CoefW-1:0] rom_data;

  assign k_prod   = (PhaseW+DBW)'(phase_q) * (PhaseW+DBW)'(SINE_TABLE_DEPTH);
  assign k_next   = k_prod[PhaseW +: KW];
  assign kc_sum   = (KW+1)'(k_q) + (KW+1)'(QUARTER);
  assign kc_wrap  = kc_sum - (KW+1)'(SINE_TABLE_DEPTH);
  assign kc       = (kc_sum >= (KW+1)'(SINE_TABLE_DEPTH)) ? kc_wrap[KW-1:0] : kc_sum[KW-1:0];
  assign rom_addr = (state_q == S_COS_RD) ? kc : k_q;

  cosg_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // shared multiplier, once for sine and once for cosine
  logic               scale_en;
  logic [RadiusW-1:0] scale_mag;
  logic               scale_neg;

  assign scale_en = (state_q == S_SIN_MUL) || (state_q == S_COS_MUL);

  cosg_scale u_scale (
    .clk_i    (clk_i),
    .en_i     (scale_en),
    .radius_i (radius_q),
    .coef_i   (rom_data),
    .mag_o    (scale_mag),
    .neg_o    (scale_neg)
  );

  // x = cx - r*sin, y = cy + r*cos
  logic                    acc_sub;
  coord_t                  acc_base;
  logic signed [CoordW:0]  base_ext, p_ext, acc;
  coord_t                  acc_sat;

  assign acc_base = (state_q == S_X) ? center_x_q : center_y_q;
  assign acc_sub  = (state_q == S_X) ^ scale_neg;
  assign base_ext = (CoordW+1)'(acc_base);
  assign p_ext    = $signed((CoordW+1)'(scale_mag));
  assign acc      = acc_sub ? (base_ext - p_ext) : (base_ext + p_ext);
  assign acc_sat  = sat_coord(acc);

  // visibility of the current vertex, bounds inclusive
  logic [CMPW-1:0] w_ext, h_ext;
  logic            on_cur;

  assign w_ext  = CMPW'(canvas_w_q) << COORD_FRAC_BITS;
  assign h_ext  = CMPW'(canvas_h_q) << COORD_FRAC_BITS;
  assign on_cur = !x_q[CoordW-1] && !y_q[CoordW-1] &&
                  (CMPW'(x_q[CoordW-2:0]) <= w_ext) && (CMPW'(y_q[CoordW-2:0]) <= h_ext);

  logic [ThickW-1:0] thickness;
  logic              out_free;
  logic              last_vertex;
  logic              vert_done;
  logic              close_load;
  logic              out_load;

  assign thickness   = (line_w_q == '0) ? ThickW'(1) : line_w_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign last_vertex = (NW'(cnt_q) == (n_q - NW'(1)));
  // vertex 0 emits nothing; later vertices need the output register free
  assign vert_done   = (state_q == S_VERT) && ((cnt_q == '0) || out_free);
  assign close_load  = (state_q == S_CLOSE) && out_free;
  assign out_load    = (vert_done && (cnt_q != '0)) || close_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      center_x_q  <= '0;
      center_y_q  <= '0;
      radius_q    <= '0;
      k_q         <= '0;
      x_q         <= '0;
      y_q         <= '0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      first_on_q  <= 1'b0;
      prev_on_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            center_x_q <= in_item_i.center_x;
            center_y_q <= in_item_i.center_y;
            radius_q   <= in_item_i.radius;
            n_q        <= n_clamped;
            state_q    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            step_q  <= div_quot[PhaseW-1:0];
            state_q <= S_INDEX;
          end
        end
        S_INDEX: begin
          k_q     <= k_next;
          state_q <= S_SIN_RD;
        end
        S_SIN_RD:  state_q <= S_SIN_MUL;
        S_SIN_MUL: state_q <= S_X;
        S_X: begin
          x_q     <= acc_sat;
          state_q <= S_COS_RD;
        end
        S_COS_RD:  state_q <= S_COS_MUL;
        S_COS_MUL: state_q <= S_Y;
        S_Y: begin
          y_q     <= acc_sat;
          state_q <= S_VERT;
        end
        S_VERT: begin
          if (vert_done) begin
            if (cnt_q == '0) begin
              first_x_q  <= x_q;
              first_y_q  <= y_q;
              first_on_q <= on_cur;
            end else begin
              out_item_q.start_x   <= prev_x_q;
              out_item_q.start_y   <= prev_y_q;
              out_item_q.end_x     <= x_q;
              out_item_q.end_y     <= y_q;
              out_item_q.visible   <= prev_on_q || on_cur;
              out_item_q.thickness <= thickness;
              out_item_q.last      <= 1'b0;
            end
            prev_x_q  <= x_q;
            prev_y_q  <= y_q;
            prev_on_q <= on_cur;
            phase_q   <= phase_q + step_q;
            if (last_vertex) begin
              cnt_q   <= '0;
              state_q <= S_CLOSE;
            end else begin
              cnt_q   <= cnt_q + CW'(1);
              state_q <= S_INDEX;
            end
          end
        end
        S_CLOSE: begin
          if (close_load) begin
            out_item_q.start_x   <= prev_x_q;
            out_item_q.start_y   <= prev_y_q;
            out_item_q.end_x     <= first_x_q;
            out_item_q.end_y     <= first_y_q;
            out_item_q.visible   <= prev_on_q || first_on_q;
            out_item_q.thickness <= thickness;
            out_item_q.last      <= 1'b1;
            phase_q              <= '0;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q == '0) && (phase_q == '0))
    else $error("vertex counter or phase not cleared between requests");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (NW'(cnt_q) < n_q))
    else $error("vertex counter beyond vertex count");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_close_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_load |=> in_ready_o && out_valid_o && out_item_o.last)
    else $error("closing segment transfer did not end the request");

endmodule

// ===== tb/tb_circle_outline_segment_generator.sv =====
`timescale 1ns / 1ps
// Testbench for circle_outline_segment_generator: random and directed circles, scored per segment.
module tb_circle_outline_segment_generator;
  import cosg_pkg::*;

  localparam int MaxVertices = 64;
  localparam int SineDepth   = 256;
  localparam int FracBits    = 4;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 2'd3;
  localparam int RandPerPhase = 73;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_CANVAS_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  circle_outline_segment_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  // predictor copy of the register file
  logic [CanvasW-1:0] canvas_w = 14'd1920;
  logic [CanvasW-1:0] canvas_h = 14'd1080;
  logic [ThickW-1:0]  line_w   = 8'd1;

  in_item_t  request_q[$];
  out_item_t segment_q[$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int unsigned mismatch_count  = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  logic in_taken = 1'b0;
  out_item_t want;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL circle_outline_segment_generator");
    $finish;
  end

  // Q1.15 sine from quarter-wave polynomial
  function automatic longint sine_q15(input longint unsigned k);
    longint unsigned k4, q, m, xq, x, x2, t, s, mag;
    k4 = (k % SineDepth) * 4;
    q = k4 / SineDepth;
    m = k4 - q * SineDepth;
    xq = (m << 16) / SineDepth;
    x = q[0] ? (65536 - xq) : xq;
    x2 = (x * x) >> 16;
    t = (5223 * x2) >> 16;
    t = 42334 - t;
    t = (t * x2) >> 16;
    t = 102944 - t;
    s = (t * x) >> 16;
    mag = (s + 1) >> 1;
    if (mag > 32767) mag = 32767;
    return (q >= 2) ? -longint'(mag) : longint'(mag);
  endfunction

  // r * coef, rounded half away from zero back to 1/16 pixel
  function automatic longint scale_radius(input longint unsigned r, input longint coef);
    longint unsigned mag, p;
    mag = (coef < 0) ? longint'(-coef) : longint'(coef);
    p = (r * mag + 16384) >> 15;
    return (coef < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > 524287) return CoordMax;
    if (v < -524288) return CoordMin;
    return coord_t'(v);
  endfunction

  function automatic logic on_canvas(input longint x, input longint y);
    longint wb, hb;
    wb = longint'(canvas_w) << FracBits;
    hb = longint'(canvas_h) << FracBits;
    return x >= 0 && y >= 0 && x <= wb && y <= hb;
  endfunction

  function automatic void push_segment(input coord_t sx, input coord_t sy,
                                       input coord_t ex, input coord_t ey, input logic fin);
    out_item_t seg;
    seg.start_x = sx;
    seg.start_y = sy;
    seg.end_x = ex;
    seg.end_y = ey;
    seg.visible = on_canvas(longint'(sx), longint'(sy)) ||
                  on_canvas(longint'(ex), longint'(ey));
    seg.thickness = (line_w == 0) ? 8'd1 : line_w;
    seg.last = fin;
    segment_q.push_back(seg);
  endfunction

  // expected segments of one circle request
  function automatic void tessellate_circle(input in_item_t req);
    longint cx, cy;
    longint unsigned r;
    int unsigned n, step, phase, k, kc;
    coord_t vx, vy, fx, fy, px, py;
    cx = longint'(req.center_x);
    cy = longint'(req.center_y);
    r = 64'(req.radius);
    n = 32'(req.vertex_count);
    if (n == 0) n = 1;
    if (n > MaxVertices) n = MaxVertices;
    step = 65536 / n;
    phase = 0;
    fx = '0;
    fy = '0;
    px = '0;
    py = '0;
    for (int unsigned i = 0; i < n; i++) begin
      k = (phase * SineDepth) >> 16;
      kc = (k + SineDepth / 4) % SineDepth;
      vx = clamp_coord(cx - scale_radius(r, sine_q15(k)));
      vy = clamp_coord(cy + scale_radius(r, sine_q15(kc)));
      if (i == 0) begin
        fx = vx;
        fy = vy;
      end else begin
        push_segment(px, py, vx, vy, 1'b0);
      end
      px = vx;
      py = vy;
      phase = (phase + step) & 32'hFFFF;
    end
    push_segment(px, py, fx, fy, 1'b1);
  endfunction

  task automatic flag_mismatch(input string what, input out_item_t exp_seg);
    if (mismatch_count < 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  exp sx=%0d sy=%0d ex=%0d ey=%0d vis=%0b th=%0d last=%0b",
               exp_seg.start_x, exp_seg.start_y, exp_seg.end_x, exp_seg.end_y,
               exp_seg.visible, exp_seg.thickness, exp_seg.last);
      $display("  got sx=%0d sy=%0d ex=%0d ey=%0d vis=%0b th=%0d last=%0b",
               out_item.start_x, out_item.start_y, out_item.end_x, out_item.end_y,
               out_item.visible, out_item.thickness, out_item.last);
    end
    mismatch_count++;
  endtask

  // request driver and result receiver
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_taken)) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on request transfer, score on segment transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        tessellate_circle(in_item);
        requests_taken++;
      end
      if (out_valid && out_ready) begin
        if (segment_q.size() == 0) begin
          flag_mismatch("segment with nothing expected", '0);
        end else begin
          want = segment_q.pop_front();
          if (want.start_x !== out_item.start_x || want.start_y !== out_item.start_y ||
              want.end_x !== out_item.end_x || want.end_y !== out_item.end_y ||
              want.visible !== out_item.visible || want.thickness !== out_item.thickness ||
              want.last !== out_item.last) begin
            flag_mismatch("segment mismatch", want);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      REG_CANVAS_WIDTH:  canvas_w = val;
      REG_CANVAS_HEIGHT: canvas_h = val;
      REG_LINE_WIDTH:    line_w = val[ThickW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_canvas(input int w, input int h, input int lw);
    write_reg(REG_CANVAS_WIDTH, CfgDataW'(w));
    write_reg(REG_CANVAS_HEIGHT, CfgDataW'(h));
    write_reg(REG_LINE_WIDTH, CfgDataW'(lw));
  endtask

  task automatic queue_circle(input int cx, input int cy, input int r, input int n);
    in_item_t req;
    req.center_x = CoordW'(cx);
    req.center_y = CoordW'(cy);
    req.radius = RadiusW'(r);
    req.vertex_count = VertexCountW'(n);
    request_q.push_back(req);
    requests_queued++;
  endtask

  task automatic queue_random_circle();
    int cx, cy, r, n, sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) n = $urandom_range(1, 16);
    else if (sel < 90) n = $urandom_range(17, 64);
    else n = $urandom_range(0, 127);
    sel = $urandom_range(0, 99);
    if (sel < 55) r = $urandom_range(0, 8000);
    else if (sel < 90) r = $urandom_range(0, 262143);
    else r = $urandom_range(0, 1) ? 262143 : 0;
    if ($urandom_range(0, 1)) begin
      cx = $urandom_range(0, int'(canvas_w) * 16 + 2000) - 1000;
      cy = $urandom_range(0, int'(canvas_h) * 16 + 2000) - 1000;
    end else begin
      cx = $urandom_range(0, 20'hFFFFF);
      cy = $urandom_range(0, 20'hFFFFF);
    end
    queue_circle(cx, cy, r, n);
  endtask

  task automatic wait_drained();
    while (requests_taken != requests_queued || segment_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pass on reset register values
    send_idle_pct = 15;
    recv_stall_pct = 15;
    queue_circle(15360, 8640, 1600, 8);
    queue_circle(15360, 8640, 1600, 0);    // zero count acts as one vertex
    queue_circle(15360, 8640, 1600, 1);
    queue_circle(15360, 8640, 1600, 2);
    queue_circle(15360, 8640, 1600, 3);
    queue_circle(15360, 8640, 800, 64);
    queue_circle(15360, 8640, 800, 65);    // clamped to the maximum
    queue_circle(15360, 8640, 800, 127);
    queue_circle(100, 100, 0, 5);
    queue_circle(0, 0, 262143, 16);
    queue_circle(524287, 524287, 262143, 12);     // saturates high
    queue_circle(-524288, -524288, 262143, 12);   // saturates low
    queue_circle(524287, -524288, 1000, 4);
    queue_circle(-1, -1, 16, 4);
    queue_circle(0, 0, 0, 1);                     // corner, inclusive bound
    queue_circle(30720, 17280, 0, 1);             // far corner, inclusive bound
    queue_circle(30721, 0, 0, 1);                 // just outside
    queue_circle(15360, -1, 0, 1);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_canvas(16383, 16383, 255);
        end
        1: begin
          send_idle_pct = 85;
          recv_stall_pct = 0;
          set_canvas(0, 0, 0);                    // zero width goes out as one
          write_reg(RegUnmapped, 14'h3FFF);       // no register there
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 85;
          set_canvas($urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(0, 16383));
        end
        default: begin
          send_idle_pct = 15;
          recv_stall_pct = 15;
          set_canvas($urandom_range(1, 4000), $urandom_range(1, 4000),
                     $urandom_range(1, 255));
        end
      endcase
      repeat (RandPerPhase) queue_random_circle();
      wait_drained();
    end

    // wait out the tail of the last request; catch any stray segment
    repeat (600) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS circle_outline_segment_generator");
    end else begin
      $display("FAIL circle_outline_segment_generator");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cosg_pkg.sv
sv/cosg_div.sv
sv/cosg_sine_rom.sv
sv/cosg_scale.sv
sv/circle_outline_segment_generator.sv
tb/tb_circle_outline_segment_generator.sv
